// File: design/ber_tlv_element_encoder_top_assert.svh
// Assertion macros for the BER element encoder top level.
`ifndef BER_TLV_ELEMENT_ENCODER_TOP_ASSERT_SVH
`define BER_TLV_ELEMENT_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("BER encoder same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("BER encoder next-cycle check failed");

`endif

// File: design/bte_pkg.sv
// Shared types and constants of the BER element encoder.
package bte_pkg;

    localparam int unsigned MAX_BYTES = 6;
    localparam int unsigned CNT_W     = 3;

    localparam logic [2:0] CMD_TAG        = 3'd0;
    localparam logic [2:0] CMD_LENGTH     = 3'd1;
    localparam logic [2:0] CMD_INTEGER    = 3'd2;
    localparam logic [2:0] CMD_INDEFINITE = 3'd3;
    localparam logic [2:0] CMD_EOC        = 3'd4;
    localparam logic [2:0] CMD_NULL       = 3'd5;

    localparam logic [4:0] TAG_LONG_FORM = 5'd31;
    localparam logic [7:0] LONG_FLAG     = 8'h80;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic none;
        logic last;
    } t_dp_sts;

endpackage

// File: design/bte_datapath.sv
// Datapath: builds the byte sequence of one element piece and shifts it out.
module bte_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bte_pkg::t_dp_cmd    i_cmd,
    output bte_pkg::t_dp_sts    o_sts,
    input  logic [2:0]          i_command,
    input  logic [1:0]          i_tag_class,
    input  logic                i_constructed,
    input  logic [31:0]         i_tag_number,
    input  logic [30:0]         i_length_value,
    input  logic [31:0]         i_int_value,
    output logic [7:0]          o_out_byte
);

    logic [7:0]                 r_buf [0:bte_pkg::MAX_BYTES-1];
    logic [bte_pkg::CNT_W-1:0]  r_cnt;

    logic [7:0]                 ld_buf [0:bte_pkg::MAX_BYTES-1];
    logic [bte_pkg::CNT_W-1:0]  ld_cnt;

    logic [34:0]                tag_pad;
    logic [6:0]                 grp [0:4];
    logic [2:0]                 groups;
    logic [2:0]                 len_cnt;
    logic [2:0]                 int_cnt;
    logic [7:0]                 len_b [0:3];
    logic [7:0]                 int_b [0:3];
    logic [7:0]                 id_byte;

    always_comb begin
        tag_pad = {3'b000, i_tag_number};
        for (int k = 0; k < 5; k++) begin
            grp[k] = tag_pad[7*k +: 7];
        end
        for (int k = 0; k < 4; k++) begin
            len_b[k] = 8'({1'b0, i_length_value} >> (8 * k));
            int_b[k] = i_int_value[8*k +: 8];
        end
        id_byte = {i_tag_class, i_constructed, 5'b00000};

        // Base-128 group count of the tag number.
        priority if (i_tag_number[31:28] != '0) groups = 3'd5;
        else if (i_tag_number[27:21] != '0)     groups = 3'd4;
        else if (i_tag_number[20:14] != '0)     groups = 3'd3;
        else if (i_tag_number[13:7] != '0)      groups = 3'd2;
        else                                    groups = 3'd1;

        priority if (i_length_value[30:24] != '0) len_cnt = 3'd4;
        else if (i_length_value[23:16] != '0)     len_cnt = 3'd3;
        else if (i_length_value[15:8] != '0)      len_cnt = 3'd2;
        else                                      len_cnt = 3'd1;

        // A leading byte goes while it and the next top bit are pure sign.
        priority if (i_int_value[31:23] != '0 && i_int_value[31:23] != '1) int_cnt = 3'd4;
        else if (i_int_value[23:15] != '0 && i_int_value[23:15] != '1)     int_cnt = 3'd3;
        else if (i_int_value[15:7] != '0 && i_int_value[15:7] != '1)       int_cnt = 3'd2;
        else                                                               int_cnt = 3'd1;

        for (int i = 0; i < bte_pkg::MAX_BYTES; i++) begin
            ld_buf[i] = 8'h00;
        end
        ld_cnt = '0;

        unique case (i_command)
            bte_pkg::CMD_TAG: begin
                if (i_tag_number < 32'(bte_pkg::TAG_LONG_FORM)) begin
                    ld_buf[0] = id_byte | {3'b000, i_tag_number[4:0]};
                    ld_cnt    = 3'd1;
                end else begin
                    ld_buf[0] = id_byte | {3'b000, bte_pkg::TAG_LONG_FORM};
                    for (int i = 1; i < bte_pkg::MAX_BYTES; i++) begin
                        if (3'(i) <= groups) begin
                            ld_buf[i] = {(3'(i) < groups), grp[3'(groups - 3'(i))]};
                        end
                    end
                    ld_cnt = groups + 3'd1;
                end
            end
            bte_pkg::CMD_LENGTH: begin
                if (i_length_value < 31'd128) begin
                    ld_buf[0] = i_length_value[7:0];
                    ld_cnt    = 3'd1;
                end else begin
                    ld_buf[0] = bte_pkg::LONG_FLAG | {5'b00000, len_cnt};
                    for (int i = 1; i < 5; i++) begin
                        if (3'(i) <= len_cnt) begin
                            ld_buf[i] = len_b[2'(len_cnt - 3'(i))];
                        end
                    end
                    ld_cnt = len_cnt + 3'd1;
                end
            end
            bte_pkg::CMD_INTEGER: begin
                ld_buf[0] = {5'b00000, int_cnt};
                for (int i = 1; i < 5; i++) begin
                    if (3'(i) <= int_cnt) begin
                        ld_buf[i] = int_b[2'(int_cnt - 3'(i))];
                    end
                end
                ld_cnt = int_cnt + 3'd1;
            end
            bte_pkg::CMD_INDEFINITE: begin
                ld_buf[0] = bte_pkg::LONG_FLAG;
                ld_cnt    = 3'd1;
            end
            bte_pkg::CMD_EOC: begin
                ld_cnt = 3'd2;
            end
            bte_pkg::CMD_NULL: begin
                ld_cnt = 3'd1;
            end
            default: begin
                ld_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf <= ld_buf;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < bte_pkg::MAX_BYTES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[bte_pkg::MAX_BYTES-1] <= 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= ld_cnt;
        end else if (i_cmd.shift) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_sts.none = (ld_cnt == '0);
    assign o_sts.last = (r_cnt == 3'd1);
    assign o_out_byte = r_buf[0];

endmodule

// File: design/bte_ctrl.sv
// Controller: handshakes of both channels and the load/shift sequencing.
module bte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  bte_pkg::t_dp_sts    i_sts,
    output bte_pkg::t_dp_cmd    o_cmd
);

    bte_pkg::t_state r_state;
    bte_pkg::t_state n_state;

    logic in_acc;
    logic out_acc;
    logic done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_valid = 1'b0;
        unique case (r_state)
            bte_pkg::ST_IDLE: o_valid = 1'b0;
            bte_pkg::ST_EMIT: o_valid = 1'b1;
            default:          o_valid = 1'b0;
        endcase
        out_acc = o_valid && !i_stall;
        done    = out_acc && i_sts.last;
        // A new word is taken as soon as the final byte of the current one leaves.
        o_stall = o_valid && !done;
        in_acc  = i_valid && !o_stall;

        o_cmd.load  = in_acc;
        o_cmd.shift = out_acc && !i_sts.last;

        n_state = r_state;
        if (in_acc) begin
            n_state = i_sts.none ? bte_pkg::ST_IDLE : bte_pkg::ST_EMIT;
        end else if (done) begin
            n_state = bte_pkg::ST_IDLE;
        end
    end

endmodule

// File: design/ber_tlv_element_encoder_top.sv
// BER element encoder: turns one tag, length or integer word into bytes.
//
// Input channel: i_valid with i_command and its operand fields; the word is
// taken on a rising edge with i_valid high and o_stall low. Output channel:
// o_valid with o_out_byte and o_last; a byte leaves on a rising edge with
// o_valid high and i_stall low, and o_last marks the final byte of a word.
// The first byte is presented the cycle after the word is taken. The word is
// encoded into a six-byte shift register in that cycle, then one byte leaves
// per cycle while i_stall is low, so a word carries 1 to 6 bytes (six at most
// for a long tag). The next word is taken on the edge where the final byte
// of the current one leaves, so words follow with no gap. Commands 6 and 7
// are taken and produce no bytes.
// A stall from the receiver holds the current byte and keeps o_stall high.
// Synchronous reset (i_rst_n low) empties the block; o_valid drops and a new
// word can be taken on the first edge after reset.
`include "ber_tlv_element_encoder_top_assert.svh"

module ber_tlv_element_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_command,
    input  logic [1:0]          i_tag_class,
    input  logic                i_constructed,
    input  logic [31:0]         i_tag_number,
    input  logic [30:0]         i_length_value,
    input  logic signed [31:0]  i_int_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    bte_pkg::t_dp_cmd dp_cmd;
    bte_pkg::t_dp_sts dp_sts;

    bte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    bte_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_command      (i_command),
        .i_tag_class    (i_tag_class),
        .i_constructed  (i_constructed),
        .i_tag_number   (i_tag_number),
        .i_length_value (i_length_value),
        .i_int_value    ($unsigned(i_int_value)),
        .o_out_byte     (o_out_byte)
    );

    assign o_last = dp_sts.last;

    `BTE_ASSERT_NOW(a_take_only_at_end, o_valid && !o_stall, o_last && !i_stall)
    `BTE_ASSERT_NEXT(a_more_bytes_follow, o_valid && !i_stall && !o_last, o_valid)
    `BTE_ASSERT_NEXT(a_idle_after_last, o_valid && !i_stall && o_last && !i_valid, !o_valid)

endmodule

// File: verif/ber_tlv_element_encoder_checker.sv
// Checker for the BER element encoder: predicts the encoded bytes of each word and compares them.
`timescale 1ns / 100ps

module ber_tlv_element_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_command,
    input  logic [1:0]  i_tag_class,
    input  logic        i_constructed,
    input  logic [31:0] i_tag_number,
    input  logic [30:0] i_length_value,
    input  logic [31:0] i_int_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_bytes_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_enc_byte;

    t_enc_byte encoded_bytes_q[$];
    int        mismatch_count = 0;
    int        checked_count  = 0;

    assign o_mismatches    = mismatch_count;
    assign o_bytes_checked = checked_count;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
    endtask

    // Encodes one word into its BER bytes and queues them in order.
    task automatic predict_encoding(input logic [2:0] cmd, input logic [1:0] cls,
                                    input logic cons, input logic [31:0] num,
                                    input logic [30:0] len, input logic [31:0] ival);
        logic [7:0]  enc [0:5];
        logic [31:0] shifted;
        logic [31:0] len_word;
        logic [8:0]  top_bits;
        logic        fixed;
        int          n;
        int          groups;
        int          cnt;
        t_enc_byte   entry;
        n        = 0;
        len_word = {1'b0, len};
        case (cmd)
            bte_pkg::CMD_TAG: begin
                if (num < 32'(bte_pkg::TAG_LONG_FORM)) begin
                    enc[n] = {cls, cons, num[4:0]};
                    n++;
                end else begin
                    enc[n] = {cls, cons, bte_pkg::TAG_LONG_FORM};
                    n++;
                    groups = 1;
                    while (groups < 5 && (num >> (7 * groups)) != 0) groups++;
                    // Every group but the least significant carries the continuation bit.
                    for (int g = groups - 1; g > 0; g--) begin
                        shifted = num >> (7 * g);
                        enc[n] = {1'b1, shifted[6:0]};
                        n++;
                    end
                    enc[n] = {1'b0, num[6:0]};
                    n++;
                end
            end
            bte_pkg::CMD_LENGTH: begin
                if (len_word < 128) begin
                    enc[n] = len_word[7:0];
                    n++;
                end else begin
                    cnt = 4;
                    while (cnt > 1 && ((len_word >> (8 * (cnt - 1))) & 32'hff) == 0) cnt--;
                    enc[n] = bte_pkg::LONG_FLAG | 8'(cnt);
                    n++;
                    for (int k = cnt - 1; k >= 0; k--) begin
                        shifted = len_word >> (8 * k);
                        enc[n] = shifted[7:0];
                        n++;
                    end
                end
            end
            bte_pkg::CMD_INTEGER: begin
                // A leading byte goes while it and the top bit of the next one are all sign.
                cnt   = 4;
                fixed = 1'b0;
                while (cnt > 1 && !fixed) begin
                    shifted  = ival >> (8 * cnt - 9);
                    top_bits = shifted[8:0];
                    if (top_bits != 9'h000 && top_bits != 9'h1ff)
                        fixed = 1'b1;
                    else
                        cnt--;
                end
                enc[n] = 8'(cnt);
                n++;
                for (int k = cnt - 1; k >= 0; k--) begin
                    shifted = ival >> (8 * k);
                    enc[n] = shifted[7:0];
                    n++;
                end
            end
            bte_pkg::CMD_INDEFINITE: begin
                enc[n] = bte_pkg::LONG_FLAG;
                n++;
            end
            bte_pkg::CMD_EOC: begin
                enc[n] = 8'h00;
                enc[n + 1] = 8'h00;
                n += 2;
            end
            bte_pkg::CMD_NULL: begin
                enc[n] = 8'h00;
                n++;
            end
            default: n = 0;
        endcase
        for (int i = 0; i < n; i++) begin
            entry.value = enc[i];
            entry.last  = (i == n - 1);
            encoded_bytes_q.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin
        t_enc_byte want;
        if (i_rst_n) begin
            // A byte leaving on this edge belongs to a word taken on an earlier edge.
            if (i_out_valid && !i_out_stall) begin
                if (encoded_bytes_q.size() == 0) begin
                    report_mismatch("unexpected byte", i_out_byte, 8'h00);
                end else begin
                    want = encoded_bytes_q.pop_front();
                    checked_count++;
                    if (i_out_byte !== want.value)
                        report_mismatch("byte value", i_out_byte, want.value);
                    if (i_out_last !== want.last)
                        report_mismatch("last flag", {7'd0, i_out_last}, {7'd0, want.last});
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_encoding(i_command, i_tag_class, i_constructed, i_tag_number,
                                 i_length_value, i_int_value);
        end
        o_pending <= encoded_bytes_q.size();
    end

endmodule

// File: verif/ber_tlv_element_encoder_top_tb.sv
// Testbench top for the BER element encoder: clock, reset, word stimulus and verdict.
`timescale 1ns / 100ps

module ber_tlv_element_encoder_top_tb;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int         RANDOM_WORDS  = 420;
    localparam int         HOLD_CYCLES   = 250;
    localparam int         CYCLE_LIMIT   = 600000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_command;
    logic [1:0]         i_tag_class;
    logic               i_constructed;
    logic [31:0]        i_tag_number;
    logic [30:0]        i_length_value;
    logic signed [31:0] i_int_value;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_out_byte;
    logic               o_last;

    int mismatches;
    int bytes_pending;
    int bytes_checked;
    int cycle_count = 0;
    int tag_words = 0;
    int length_words = 0;
    int integer_words = 0;
    int marker_words = 0;
    int unused_words = 0;

    // Control of the idling: quiet turns gaps off, the hold request asks for one long stall.
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    ber_tlv_element_encoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_tag_class    (i_tag_class),
        .i_constructed  (i_constructed),
        .i_tag_number   (i_tag_number),
        .i_length_value (i_length_value),
        .i_int_value    (i_int_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    ber_tlv_element_encoder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_tag_class     (i_tag_class),
        .i_constructed   (i_constructed),
        .i_tag_number    (i_tag_number),
        .i_length_value  (i_length_value),
        .i_int_value     (i_int_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_out_last      (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (bytes_pending),
        .o_bytes_checked (bytes_checked)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes outstanding",
                     cycle_count, bytes_pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: runs of stall and no stall, one assignment per edge.
    initial begin
        int  run_left;
        bit  stalling;
        run_left = 0;
        stalling = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left > 0) begin
                run_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stalling    = 1'b1;
                run_left    = HOLD_CYCLES;
            end else if (rx_quiet) begin
                stalling = 1'b0;
                run_left = 8;
            end else begin
                stalling = ($urandom_range(0, 99) < 30);
                if (!stalling)
                    run_left = $urandom_range(0, 7);
                else if ($urandom_range(0, 9) < 8)
                    run_left = $urandom_range(0, 2);
                else
                    run_left = $urandom_range(10, 40);
            end
            i_stall <= stalling;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Spread over all widths, with powers of two and one less than them now and then.
    function automatic logic [31:0] spread_value();
        logic [31:0] v;
        if ($urandom_range(0, 9) < 2) begin
            v = 32'd1 << $urandom_range(0, 31);
            v = v - $urandom_range(0, 1);
        end else begin
            v = $urandom >> $urandom_range(0, 31);
        end
        return v;
    endfunction

    // Offers one word, holds it until taken, then leaves a random gap.
    task automatic send_word(input logic [2:0] cmd, input logic [1:0] cls, input logic cons,
                             input logic [31:0] num, input logic [30:0] len,
                             input logic [31:0] ival);
        int gap;
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_tag_class    <= cls;
        i_constructed  <= cons;
        i_tag_number   <= num;
        i_length_value <= len;
        i_int_value    <= ival;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (cmd)
            bte_pkg::CMD_TAG:     tag_words++;
            bte_pkg::CMD_LENGTH:  length_words++;
            bte_pkg::CMD_INTEGER: integer_words++;
            bte_pkg::CMD_INDEFINITE, bte_pkg::CMD_EOC, bte_pkg::CMD_NULL: marker_words++;
            default:     unused_words++;
        endcase
        gap = sender_gap();
        if (gap > 0) begin
            i_valid        <= 1'b0;
            i_command      <= 3'($urandom);
            i_tag_number   <= $urandom;
            i_int_value    <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_word(output bit counted);
        logic [2:0]  cmd;
        logic [31:0] ival;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 30)      cmd = bte_pkg::CMD_TAG;
        else if (r < 55) cmd = bte_pkg::CMD_LENGTH;
        else if (r < 80) cmd = bte_pkg::CMD_INTEGER;
        else if (r < 85) cmd = bte_pkg::CMD_INDEFINITE;
        else if (r < 90) cmd = bte_pkg::CMD_EOC;
        else if (r < 95) cmd = bte_pkg::CMD_NULL;
        else             cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        ival = spread_value();
        if ($urandom_range(0, 1))
            ival = ~ival;
        send_word(cmd, 2'($urandom), 1'($urandom), spread_value(),
                  31'(spread_value() >> 1), ival);
        counted = (cmd != CMD_UNUSED_LO && cmd != CMD_UNUSED_HI);
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int words);
        int sent;
        bit counted;
        sent = 0;
        while (sent < words) begin
            send_random_word(counted);
            if (counted) sent++;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= bte_pkg::CMD_TAG;
        i_tag_class    <= 2'd0;
        i_constructed  <= 1'b0;
        i_tag_number   <= 32'd0;
        i_length_value <= 31'd0;
        i_int_value    <= 32'sd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tags from the shortest form up to the six byte long form.
        send_word(bte_pkg::CMD_TAG, 2'd0, 1'b0, 32'd0, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd3, 1'b1, 32'd30, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd1, 1'b0, 32'd31, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd2, 1'b1, 32'd128, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd1, 1'b1, 32'd16384, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd0, 1'b0, 32'h0fff_ffff, 31'($urandom), $urandom);
        send_word(bte_pkg::CMD_TAG, 2'd2, 1'b1, 32'hffff_ffff, 31'($urandom), $urandom);
        // Lengths on both sides of the short form limit and the widest one.
        send_word(bte_pkg::CMD_LENGTH, 2'($urandom), 1'($urandom), $urandom, 31'd0, $urandom);
        send_word(bte_pkg::CMD_LENGTH, 2'($urandom), 1'($urandom), $urandom, 31'd127, $urandom);
        send_word(bte_pkg::CMD_LENGTH, 2'($urandom), 1'($urandom), $urandom, 31'd128, $urandom);
        send_word(bte_pkg::CMD_LENGTH, 2'($urandom), 1'($urandom), $urandom, 31'h0001_0000,
                  $urandom);
        send_word(bte_pkg::CMD_LENGTH, 2'($urandom), 1'($urandom), $urandom, 31'h7fff_ffff,
                  $urandom);
        // Integers: zero, sign boundaries of one and two bytes, and the extremes.
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'h0000_0000);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'h0000_007f);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'h0000_0080);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'hffff_ff80);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'hffff_ff7f);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'hffff_ffff);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'h7fff_ffff);
        send_word(bte_pkg::CMD_INTEGER, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  32'h8000_0000);
        // Fixed markers, then the two codes that must produce nothing.
        send_word(bte_pkg::CMD_INDEFINITE, 2'($urandom), 1'($urandom), $urandom,
                  31'($urandom), $urandom);
        send_word(bte_pkg::CMD_EOC, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  $urandom);
        send_word(bte_pkg::CMD_NULL, 2'($urandom), 1'($urandom), $urandom, 31'($urandom),
                  $urandom);
        send_word(CMD_UNUSED_LO, 2'($urandom), 1'($urandom), $urandom, 31'($urandom), $urandom);
        send_word(CMD_UNUSED_HI, 2'($urandom), 1'($urandom), $urandom, 31'($urandom), $urandom);
        drain_all();

        run_random(120);
        drain_all();

        // The receiver holds off for a long stretch while words keep coming back to back.
        tx_quiet    = 1'b1;
        rx_hold_req = 1'b1;
        run_random(80);
        tx_quiet = 1'b0;
        drain_all();

        // A stretch with no idling on either side.
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random(100);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        run_random(80);
        drain_all();
        repeat (16) @(posedge i_clk);

        $display("Covered %0d tag, %0d length, %0d integer, %0d marker and %0d unused-code words",
                 tag_words, length_words, integer_words, marker_words, unused_words);
        $display("Compared %0d encoded bytes, with a long receiver hold and full drains",
                 bytes_checked);
        if (mismatches == 0 && bytes_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bte_pkg.sv
design/bte_datapath.sv
design/bte_ctrl.sv
design/ber_tlv_element_encoder_top.sv
verif/ber_tlv_element_encoder_checker.sv
verif/ber_tlv_element_encoder_top_tb.sv
